// ----- design/wsts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_pkg
// Types, codes and helpers shared by the work-stealing scheduler modules.
// ----------------------------------------------------------------------------
package wsts_pkg;

    localparam int DEF_MAX_WORKERS  = 8;
    localparam int DEF_QUEUE_DEPTH  = 4096;
    localparam int DEF_GLOBAL_DEPTH = 256;

    localparam logic [3:0]  RST_ACTIVE_WORKERS  = 4'd4;
    localparam logic [11:0] RST_STEAL_THRESHOLD = 12'd2;

    // Configuration register indexes.
    localparam logic REG_ACTIVE_WORKERS  = 1'b0;
    localparam logic REG_STEAL_THRESHOLD = 1'b1;

    localparam logic [1:0] CMD_SUBMIT_LOCAL  = 2'd0;
    localparam logic [1:0] CMD_SUBMIT_GLOBAL = 2'd1;
    localparam logic [1:0] CMD_FETCH         = 2'd2;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NULL = 3'd1;
    localparam logic [2:0] ST_BADW = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;

    localparam logic [1:0] SRC_OWN    = 2'd0;
    localparam logic [1:0] SRC_GLOBAL = 2'd1;
    localparam logic [1:0] SRC_STOLEN = 2'd2;

    typedef enum logic [1:0] {
        OP_LOCAL,
        OP_GLOBAL,
        OP_FETCH,
        OP_REJECT
    } t_op;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  worker;
        logic [31:0] task_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] task_out;
        logic [1:0]  source;
        logic [2:0]  victim;
    } t_out_item;

    // Classified command handed from the front end to the execution unit.
    typedef struct packed {
        t_op         op;
        logic [2:0]  worker;
        logic [31:0] task_req;
        logic [2:0]  status;
    } t_qent;

    // Number of workers in use: zero acts as one, the maximum caps it.
    function automatic logic [6:0] eff_workers(input logic [3:0] active, input int max_w);
        logic [6:0] n;
        n = {3'd0, active};
        if (active == 4'd0) begin
            n = 7'd1;
        end else if (32'(active) > max_w) begin
            n = 7'(max_w);
        end
        return n;
    endfunction

endpackage

// ----- design/work_stealing_task_scheduler.sv -----
`timescale 1ns / 1ps
// Flow: idle, execute, output for a submit or a rejected command; a fetch
// served by the worker's own deque or the global stack adds a read state; a
// fetch that scans victims examines one victim per scan step (up to the
// workers in use, less one) and reads a stolen task if one is found. The
// sequencer takes a new command only when idle; a result waits out a stall.
// Reset: synchronous, active low; pointers and stack count clear, and the
// configuration registers load their reset values.
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler
// Top level: configuration registers, classifying front end, execution unit.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler #(
    parameter int MAX_WORKERS  = wsts_pkg::DEF_MAX_WORKERS,
    parameter int QUEUE_DEPTH  = wsts_pkg::DEF_QUEUE_DEPTH,
    parameter int GLOBAL_DEPTH = wsts_pkg::DEF_GLOBAL_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [11:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wsts_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wsts_pkg::t_out_item o_out_item
);

    logic [3:0]      r_active;
    logic [11:0]     r_thresh;
    logic            q_valid;
    logic            q_pop;
    wsts_pkg::t_qent q_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= wsts_pkg::RST_ACTIVE_WORKERS;
            r_thresh <= wsts_pkg::RST_STEAL_THRESHOLD;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wsts_pkg::REG_ACTIVE_WORKERS) begin
                r_active <= i_cfg_data[3:0];
            end else begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    wsts_front #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_active_workers (r_active),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_item        (i_in_item),
        .o_q_valid        (q_valid),
        .i_q_pop          (q_pop),
        .o_q_ent          (q_ent)
    );

    wsts_back #(
        .MAX_WORKERS  (MAX_WORKERS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .GLOBAL_DEPTH (GLOBAL_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_active_workers  (r_active),
        .i_steal_threshold (r_thresh),
        .i_q_valid         (q_valid),
        .o_q_pop           (q_pop),
        .i_q_ent           (q_ent),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_item        (o_out_item)
    );

`ifndef ASSERT_OFF
    a_fail_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != wsts_pkg::ST_OK |-> o_out_item.task_out == 32'd0)
        else $error("failed command returned a task");
    a_victim_stolen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.victim != 3'd0 |-> o_out_item.source == wsts_pkg::SRC_STOLEN)
        else $error("victim reported without a steal");
    a_source_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.source != wsts_pkg::SRC_OWN |->
            o_out_item.status == wsts_pkg::ST_OK)
        else $error("fetch source on a failed command");
`endif

endmodule

// ----- design/wsts_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_front
// Accepts items, marks null, bad-worker and unused commands as rejected, and
// keeps the classified commands in a two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module wsts_front #(
    parameter int MAX_WORKERS = wsts_pkg::DEF_MAX_WORKERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_active_workers,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wsts_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output wsts_pkg::t_qent   o_q_ent
);

    wsts_pkg::t_qent r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    wsts_pkg::t_qent n_ent;
    logic [6:0]      eff_n;
    logic            push;
    logic            pop;
    logic            bad_w;
    logic            null_t;

    assign eff_n  = wsts_pkg::eff_workers(i_active_workers, MAX_WORKERS);
    assign bad_w  = {4'd0, i_in_item.worker} >= eff_n;
    assign null_t = i_in_item.task_req == 32'd0;

    always_comb begin
        n_ent.worker   = i_in_item.worker;
        n_ent.task_req = i_in_item.task_req;
        n_ent.status   = wsts_pkg::ST_OK;
        n_ent.op       = wsts_pkg::OP_REJECT;
        unique case (i_in_item.cmd)
            wsts_pkg::CMD_SUBMIT_LOCAL: begin
                if (null_t) begin
                    n_ent.status = wsts_pkg::ST_NULL;
                end else if (bad_w) begin
                    n_ent.status = wsts_pkg::ST_BADW;
                end else begin
                    n_ent.op = wsts_pkg::OP_LOCAL;
                end
            end
            wsts_pkg::CMD_SUBMIT_GLOBAL: begin
                if (null_t) begin
                    n_ent.status = wsts_pkg::ST_NULL;
                end else begin
                    n_ent.op = wsts_pkg::OP_GLOBAL;
                end
            end
            wsts_pkg::CMD_FETCH: begin
                if (bad_w) begin
                    n_ent.status = wsts_pkg::ST_BADW;
                end else begin
                    n_ent.op = wsts_pkg::OP_FETCH;
                end
            end
            default: begin
                n_ent.status = wsts_pkg::ST_NONE;
            end
        endcase
    end

    assign o_in_stall = r_cnt == 2'd2;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = r_cnt != 2'd0;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_ent    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- design/wsts_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_back
// Execution unit: owns the deque memory, the ring pointers and the global
// stack, carries out one command at a time and scans victims one per cycle.
// ----------------------------------------------------------------------------
module wsts_back #(
    parameter int MAX_WORKERS  = wsts_pkg::DEF_MAX_WORKERS,
    parameter int QUEUE_DEPTH  = wsts_pkg::DEF_QUEUE_DEPTH,
    parameter int GLOBAL_DEPTH = wsts_pkg::DEF_GLOBAL_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_active_workers,
    input  logic [11:0]        i_steal_threshold,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  wsts_pkg::t_qent    i_q_ent,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsts_pkg::t_out_item o_out_item
);

    localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int SW  = QW + 1;
    localparam int CW  = (SW > 12) ? SW : 12;
    localparam int AW  = $clog2(MAX_WORKERS * QUEUE_DEPTH);
    localparam int GIW = $clog2(GLOBAL_DEPTH);
    localparam int GCW = $clog2(GLOBAL_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_OUT
    } t_state;

    logic [31:0] r_dq_mem [MAX_WORKERS * QUEUE_DEPTH];
    logic [31:0] r_gs_mem [GLOBAL_DEPTH];
    logic [31:0] r_dq_rdata;
    logic [31:0] r_gs_rdata;

    t_state              r_state, n_state;
    logic [QW-1:0]       r_top [MAX_WORKERS];
    logic [QW-1:0]       r_bot [MAX_WORKERS];
    logic [GCW-1:0]      r_gcnt, n_gcnt;
    wsts_pkg::t_op       r_op, n_op;
    logic [WW-1:0]       r_w, n_w;
    logic [31:0]         r_task, n_task;
    logic [2:0]          r_rstat, n_rstat;
    logic [WW:0]         r_v, n_v;
    logic [6:0]          r_i, n_i;
    logic [1:0]          r_src, n_src;
    wsts_pkg::t_out_item r_out, n_out;

    logic                top_we, bot_we;
    logic [QW-1:0]       top_wdata, bot_wdata;
    logic                dq_we, dq_re, gs_we, gs_re;
    logic [AW-1:0]       dq_addr;
    logic [GIW-1:0]      gs_addr;
    logic [WW-1:0]       sel;
    logic [QW-1:0]       sel_top, sel_bot;
    logic [SW-1:0]       sel_size;
    logic [6:0]          eff_n;
    logic [WW:0]         v_inc;

    assign eff_n    = wsts_pkg::eff_workers(i_active_workers, MAX_WORKERS);
    assign sel      = (r_state == S_SCAN) ? r_v[WW-1:0] : r_w;
    assign sel_top  = r_top[sel];
    assign sel_bot  = r_bot[sel];
    assign sel_size = (sel_bot >= sel_top) ? SW'(sel_bot - sel_top)
                    : SW'({1'b0, sel_bot} + SW'(QUEUE_DEPTH) - {1'b0, sel_top});
    assign v_inc    = r_v + (WW+1)'(1);

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_state == S_OUT;
    assign o_out_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_gcnt    = r_gcnt;
        n_op      = r_op;
        n_w       = r_w;
        n_task    = r_task;
        n_rstat   = r_rstat;
        n_v       = r_v;
        n_i       = r_i;
        n_src     = r_src;
        n_out     = r_out;
        top_we    = 1'b0;
        bot_we    = 1'b0;
        top_wdata = sel_top;
        bot_wdata = sel_bot;
        dq_we     = 1'b0;
        dq_re     = 1'b0;
        gs_we     = 1'b0;
        gs_re     = 1'b0;
        dq_addr   = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(sel_bot);
        gs_addr   = r_gcnt[GIW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_op    = i_q_ent.op;
                    n_w     = WW'(i_q_ent.worker);
                    n_task  = i_q_ent.task_req;
                    n_rstat = i_q_ent.status;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out   = '{status: wsts_pkg::ST_OK, task_out: 32'd0,
                            source: wsts_pkg::SRC_OWN, victim: 3'd0};
                n_state = S_OUT;
                unique case (r_op)
                    wsts_pkg::OP_LOCAL: begin
                        if (sel_size >= SW'(QUEUE_DEPTH - 1)) begin
                            n_out.status = wsts_pkg::ST_FULL;
                        end else begin
                            dq_we     = 1'b1;
                            bot_we    = 1'b1;
                            bot_wdata = (sel_bot == QW'(QUEUE_DEPTH - 1)) ? '0
                                      : sel_bot + QW'(1);
                        end
                    end
                    wsts_pkg::OP_GLOBAL: begin
                        if (r_gcnt >= GCW'(GLOBAL_DEPTH)) begin
                            n_out.status = wsts_pkg::ST_FULL;
                        end else begin
                            gs_we  = 1'b1;
                            n_gcnt = r_gcnt + GCW'(1);
                        end
                    end
                    wsts_pkg::OP_FETCH: begin
                        if (sel_size != '0) begin
                            // Pop the bottom of the worker's own deque.
                            bot_wdata = (sel_bot == '0) ? QW'(QUEUE_DEPTH - 1)
                                      : sel_bot - QW'(1);
                            bot_we    = 1'b1;
                            dq_addr   = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(bot_wdata);
                            dq_re     = 1'b1;
                            n_src     = wsts_pkg::SRC_OWN;
                            n_state   = S_READ;
                        end else if (r_gcnt != '0) begin
                            n_gcnt  = r_gcnt - GCW'(1);
                            gs_addr = n_gcnt[GIW-1:0];
                            gs_re   = 1'b1;
                            n_src   = wsts_pkg::SRC_GLOBAL;
                            n_state = S_READ;
                        end else if (eff_n > 7'd1) begin
                            // Start the victim scan at the next worker.
                            n_i     = 7'd1;
                            n_v     = ({1'b0, r_w} + (WW+1)'(1) == (WW+1)'(eff_n))
                                    ? '0 : {1'b0, r_w} + (WW+1)'(1);
                            n_state = S_SCAN;
                        end else begin
                            n_out.status = wsts_pkg::ST_NONE;
                        end
                    end
                    default: begin
                        n_out.status = r_rstat;
                    end
                endcase
            end
            S_SCAN: begin
                if (CW'(sel_size) > CW'(i_steal_threshold)) begin
                    dq_addr   = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(sel_top);
                    dq_re     = 1'b1;
                    top_we    = 1'b1;
                    top_wdata = (sel_top == QW'(QUEUE_DEPTH - 1)) ? '0 : sel_top + QW'(1);
                    n_src     = wsts_pkg::SRC_STOLEN;
                    n_state   = S_READ;
                end else if (r_i == eff_n - 7'd1) begin
                    n_out.status = wsts_pkg::ST_NONE;
                    n_state      = S_OUT;
                end else begin
                    n_i = r_i + 7'd1;
                    n_v = (v_inc == (WW+1)'(eff_n)) ? '0 : v_inc;
                end
            end
            S_READ: begin
                n_out.status   = wsts_pkg::ST_OK;
                n_out.source   = r_src;
                n_out.task_out = (r_src == wsts_pkg::SRC_GLOBAL) ? r_gs_rdata : r_dq_rdata;
                n_out.victim   = (r_src == wsts_pkg::SRC_STOLEN) ? 3'(r_v) : 3'd0;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dq_we) begin
            r_dq_mem[dq_addr] <= r_task;
        end
        if (dq_re) begin
            r_dq_rdata <= r_dq_mem[dq_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (gs_we) begin
            r_gs_mem[gs_addr] <= r_task;
        end
        if (gs_re) begin
            r_gs_rdata <= r_gs_mem[gs_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gcnt  <= '0;
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_top[k] <= '0;
                r_bot[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_gcnt  <= n_gcnt;
            if (top_we) begin
                r_top[sel] <= top_wdata;
            end
            if (bot_we) begin
                r_bot[sel] <= bot_wdata;
            end
        end
        r_op    <= n_op;
        r_w     <= n_w;
        r_task  <= n_task;
        r_rstat <= n_rstat;
        r_v     <= n_v;
        r_i     <= n_i;
        r_src   <= n_src;
        r_out   <= n_out;
    end

endmodule
